// File: design/sbd_pkg.sv
// Shared types and constants for the stereo bit crusher and sample-rate reducer.
// Holds the register indexes, fixed field widths and the controller/datapath structs.
// Depends on nothing.
package sbd_pkg;

  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_DEPTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WET       = 2'd3;

  localparam int DEPTH_W = 5;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN = 5'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 5'd16;
  localparam int DEPTH_MAX_I = 16;

  localparam int HOLD_W = 6;

  typedef struct packed {
    logic latch_in;
    logic pass;
    logic quant;
    logic div_step;
    logic store;
    logic mul;
    logic add;
    logic out_load;
    logic ch;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: design/sbd_cfg.sv
// Configuration register file with range clamping on write.
// Raises a clear pulse for the hold state when enable is written low.
// Depends on sbd_pkg.
module sbd_cfg #(
  parameter int MAX_HOLD      = 32,
  parameter int MIX_FRAC_BITS = 12,
  parameter int CW            = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [MIX_FRAC_BITS:0]         cfg_data,
  output logic                           enable,
  output logic [sbd_pkg::DEPTH_W-1:0]    bit_depth,
  output logic [CW-1:0]                  hold,
  output logic [MIX_FRAC_BITS:0]         wet,
  output logic                           hold_clear
);
  import sbd_pkg::*;

  localparam logic [MIX_FRAC_BITS:0] WET_FULL = (MIX_FRAC_BITS+1)'(1) << MIX_FRAC_BITS;

  logic [DEPTH_W-1:0]      depth_raw;
  logic [DEPTH_W-1:0]      depth_clamped;
  logic [HOLD_W-1:0]       hold_raw;
  logic [CW-1:0]           hold_clamped;
  logic [MIX_FRAC_BITS:0]  wet_clamped;

  assign depth_raw = cfg_data[DEPTH_W-1:0];
  assign hold_raw  = cfg_data[HOLD_W-1:0];

  always_comb begin
    priority if (depth_raw < DEPTH_MIN) begin
      depth_clamped = DEPTH_MIN;
    end else if (depth_raw > DEPTH_MAX) begin
      depth_clamped = DEPTH_MAX;
    end else begin
      depth_clamped = depth_raw;
    end
    priority if (hold_raw == '0) begin
      hold_clamped = CW'(1);
    end else if (int'(hold_raw) > MAX_HOLD) begin
      hold_clamped = CW'(MAX_HOLD);
    end else begin
      hold_clamped = CW'(hold_raw);
    end
    wet_clamped = (cfg_data > WET_FULL) ? WET_FULL : cfg_data;
  end

  assign hold_clear = cfg_we && (cfg_index == REG_ENABLE) && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      bit_depth <= DEPTH_MAX;
      hold      <= CW'(1);
      wet       <= WET_FULL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:    enable    <= cfg_data[0];
        REG_BIT_DEPTH: bit_depth <= depth_clamped;
        REG_HOLD:      hold      <= hold_clamped;
        REG_WET:       wet       <= wet_clamped;
      endcase
    end
  end

endmodule

// File: design/sbd_ctrl.sv
// Controller state machine: sequences quantize, divide, store, multiply and add steps.
// Also keeps the hold countdown. Depends on sbd_pkg.
module sbd_ctrl #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_HOLD    = 32,
  parameter int CW          = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             enable,
  input  logic [CW-1:0]    hold,
  input  logic             hold_clear,
  input  sbd_pkg::status_t status,
  output sbd_pkg::cmd_t    cmd
);
  import sbd_pkg::*;

  localparam int STEPS = SAMPLE_BITS + 1;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLE_BITS);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_QUANT = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_STORE = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             ch, ch_next;
  logic [CW-1:0]    countdown;
  logic             accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ch_next    = ch;
    cmd        = '0;
    cmd.ch     = ch;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          cmd.pass     = !enable;
          ch_next      = 1'b0;
          priority if (!enable) begin
            state_next = ST_FIN;
          end else if (countdown == '0) begin
            state_next = ST_QUANT;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_QUANT: begin
        cmd.quant  = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == LAST) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (!ch) begin
          ch_next    = 1'b1;
          state_next = ST_QUANT;
        end else begin
          ch_next    = 1'b0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (!ch) begin
          ch_next    = 1'b1;
          state_next = ST_MUL;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      ch        <= 1'b0;
      countdown <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ch    <= ch_next;
      if (hold_clear) begin
        countdown <= '0;
      end else if (accept && enable) begin
        countdown <= ((countdown == '0) ? hold : countdown) - CW'(1);
      end
    end
  end

  a_pass_to_fin: assert property (@(posedge clk) disable iff (rst)
    (accept && !enable) |=> (state == ST_FIN))
    else $error("pass-through word did not go straight to the output stage");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt <= LAST))
    else $error("divider step count ran past the quotient width");

  a_clear_countdown: assert property (@(posedge clk) disable iff (rst)
    hold_clear |=> (countdown == '0))
    else $error("hold countdown not cleared after disable");

  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !status.out_free) |=> (state == ST_FIN))
    else $error("result left the output stage while the output register was full");

  a_countdown_range: assert property (@(posedge clk) disable iff (rst)
    int'(countdown) < MAX_HOLD || int'(countdown) == MAX_HOLD)
    else $error("hold countdown above the maximum hold");

endmodule

// File: design/sbd_dp.sv
// Datapath: input latch, quantizer, restoring divider, shared mix multiplier and output register.
// Driven by the controller through command and status structs. Depends on sbd_pkg.
module sbd_dp #(
  parameter int SAMPLE_BITS   = 16,
  parameter int MIX_FRAC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sbd_pkg::cmd_t                   cmd,
  output sbd_pkg::status_t                status,
  input  logic signed [SAMPLE_BITS-1:0]   left_in,
  input  logic signed [SAMPLE_BITS-1:0]   right_in,
  input  logic [sbd_pkg::DEPTH_W-1:0]     bit_depth,
  input  logic [MIX_FRAC_BITS:0]          wet,
  input  logic                            hold_clear,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]   left_out,
  output logic signed [SAMPLE_BITS-1:0]   right_out
);
  import sbd_pkg::*;

  localparam int S     = SAMPLE_BITS;
  localparam int LW    = DEPTH_MAX_I;
  localparam int TW    = S + LW + 1;
  localparam int NW    = S + LW + 2;
  localparam int RW    = LW + 1;
  localparam int QW    = S + 1;
  localparam int PW    = S + MIX_FRAC_BITS + 3;
  localparam int SW    = S + MIX_FRAC_BITS + 4;
  localparam int XW    = S + 4;
  localparam logic signed [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};
  localparam logic [TW-1:0] TBIAS = TW'(1) << (S - 1);
  localparam logic signed [SW-1:0] MIX_HALF = SW'(1) << (MIX_FRAC_BITS - 1);

  logic signed [S-1:0]  dry_l, dry_r, held_l, held_r, res_l, res_r;
  logic signed [S-1:0]  dry_sel, held_sel, held_new, mix_sat;
  logic [S-1:0]         u;
  logic [LW-1:0]        lv;
  logic [TW-1:0]        t;
  logic [LW-1:0]        q;
  logic [NW-1:0]        n;
  logic [RW-1:0]        rem, dvs;
  logic [RW:0]          r2;
  logic                 ge;
  logic [QW-1:0]        low, quo;
  logic signed [S:0]    diff;
  logic signed [PW-1:0] diff_x, m_x, prod;
  logic signed [SW-1:0] dry_x, sum;
  logic signed [XW-1:0] mix_r;

  assign dry_sel  = cmd.ch ? dry_r : dry_l;
  assign held_sel = cmd.ch ? held_r : held_l;

  assign u  = {~dry_sel[S-1], dry_sel[S-2:0]};
  assign lv = LW'(((LW+1)'(1) << bit_depth) - (LW+1)'(1));
  assign t  = (TW'(u) << bit_depth) - TW'(u) + TBIAS;
  assign q  = t[S+LW-1:S];
  assign n  = (NW'(q) << (S + 1)) + NW'(lv);

  assign r2 = {rem, low[QW-1]};
  assign ge = (r2 >= {1'b0, dvs});

  assign held_new = quo[QW-1] ? SMAX : {~quo[S-1], quo[S-2:0]};

  assign diff   = $signed({held_sel[S-1], held_sel}) - $signed({dry_sel[S-1], dry_sel});
  assign diff_x = PW'(diff);
  assign m_x    = $signed(PW'(wet));
  assign dry_x  = SW'(dry_sel);
  assign sum    = (dry_x <<< MIX_FRAC_BITS) + SW'(prod) + MIX_HALF;
  assign mix_r  = sum[SW-1:MIX_FRAC_BITS];

  always_comb begin
    if ((&mix_r[XW-1:S-1]) || !(|mix_r[XW-1:S-1])) begin
      mix_sat = mix_r[S-1:0];
    end else begin
      mix_sat = mix_r[XW-1] ? SMIN : SMAX;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      dry_l <= left_in;
      dry_r <= right_in;
    end
    if (cmd.latch_in && cmd.pass) begin
      res_l <= left_in;
      res_r <= right_in;
    end
    if (cmd.quant) begin
      rem <= n[NW-1:QW];
      low <= n[QW-1:0];
      dvs <= {lv, 1'b0};
      quo <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? RW'(r2 - {1'b0, dvs}) : r2[RW-1:0];
      low <= {low[QW-2:0], 1'b0};
      quo <= {quo[QW-2:0], ge};
    end
    if (cmd.mul) begin
      prod <= diff_x * m_x;
    end
    if (cmd.add) begin
      if (cmd.ch) begin
        res_r <= mix_sat;
      end else begin
        res_l <= mix_sat;
      end
    end
    if (cmd.out_load) begin
      left_out  <= res_l;
      right_out <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_l    <= '0;
      held_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (hold_clear) begin
        held_l <= '0;
        held_r <= '0;
      end else if (cmd.store) begin
        if (cmd.ch) begin
          held_r <= held_new;
        end else begin
          held_l <= held_new;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/stereo_bitcrush_downsample.sv
// Top level of the stereo bit crusher with sample-rate reduction.
// Instantiates sbd_cfg, sbd_ctrl and sbd_dp; depends on sbd_pkg.
//
// Usage: one stereo word (left_in, right_in) enters on in_valid while in_stall is low,
// and one processed word (left_out, right_out) leaves on out_valid while out_stall is low.
// Registers are written through cfg_we, cfg_index and cfg_data while the block is idle.
// Steps from accept until the next word can be taken:
//   pass-through (enable low): straight to the output stage;
//   held sample reused: two multiply and add passes on the shared multiplier;
//   new capture: the bit-serial restoring divider maps each quantized level back to full
//   scale, one channel after the other, followed by the two multiply and add passes.
// The output stage waits while the output register is full, then loads the result into it.
// The output register holds one finished word, so the next word is taken while the result
// waits; when the receiver stalls, the finished word holds and a second result waits
// inside the block until the output register frees.
// Reset clears the registers to enable 0, bit depth 16, hold 1 and fully wet, and clears
// the countdown, the held samples and the output valid.
module stereo_bitcrush_downsample #(
  parameter int SAMPLE_BITS   = 16,
  parameter int MAX_HOLD      = 32,
  parameter int MIX_FRAC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   left_in,
  input  logic signed [SAMPLE_BITS-1:0]   right_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]   left_out,
  output logic signed [SAMPLE_BITS-1:0]   right_out,
  input  logic                            cfg_we,
  input  logic [sbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [MIX_FRAC_BITS:0]          cfg_data
);
  import sbd_pkg::*;

  localparam int CW = $clog2(MAX_HOLD + 1);

  logic                   enable;
  logic [DEPTH_W-1:0]     bit_depth;
  logic [CW-1:0]          hold;
  logic [MIX_FRAC_BITS:0] wet;
  logic                   hold_clear;
  cmd_t                   cmd;
  status_t                status;

  sbd_cfg #(
    .MAX_HOLD      (MAX_HOLD),
    .MIX_FRAC_BITS (MIX_FRAC_BITS),
    .CW            (CW)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .enable     (enable),
    .bit_depth  (bit_depth),
    .hold       (hold),
    .wet        (wet),
    .hold_clear (hold_clear)
  );

  sbd_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_HOLD    (MAX_HOLD),
    .CW          (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .enable     (enable),
    .hold       (hold),
    .hold_clear (hold_clear),
    .status     (status),
    .cmd        (cmd)
  );

  sbd_dp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .MIX_FRAC_BITS (MIX_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .left_in    (left_in),
    .right_in   (right_in),
    .bit_depth  (bit_depth),
    .wet        (wet),
    .hold_clear (hold_clear),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .left_out   (left_out),
    .right_out  (right_out)
  );

endmodule
